>>> rtl/rx_ring_packet_deframer_top_macros.svh
// Assertion macros for the receive ring deframer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RX_RING_PACKET_DEFRAMER_TOP_MACROS_SVH
`define RX_RING_PACKET_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define RRPD_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrpd check failed");
// Next-cycle implication
`define RRPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrpd check failed");
`else
`define RRPD_ASSERT(label, clk, rst, ante, cons)
`define RRPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rrpd_pkg.sv
// Shared types and constants for the receive ring deframer.
// No dependencies; used by the channel interfaces and every RTL module.
package rrpd_pkg;

   // Ring geometry
   localparam int RING_BYTES = 8192;
   localparam int OFFSET_W   = 16;
   localparam logic [OFFSET_W-1:0] RING_MASK = OFFSET_W'(RING_BYTES - 1);

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int FLEN_W   = 11;
   localparam int PTR_W    = 13;
   localparam int DROPS_W  = 32;
   localparam int SIZE_W   = 12;
   localparam int HDR_W    = 16;

   // Header limits and framing
   localparam logic [FLEN_W-1:0]   MAX_FRAME_RESET = 11'd1518;
   localparam logic [HDR_W-1:0]    MIN_PACKET_SIZE = 16'd8;
   localparam logic [HDR_W-1:0]    CRC_BYTES       = 16'd4;
   localparam logic [OFFSET_W-1:0] PAD_ROUND       = 16'd7;
   localparam logic [OFFSET_W-1:0] HOST_PTR_BIAS   = 16'd16;

   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_DROP  = 2'd2
   } rrpd_kind_type;

   // Registered ring byte waiting for the parser
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] ring_byte;
   } rrpd_byte_type;

   // One result item
   typedef struct packed {
      rrpd_kind_type      result_kind;
      logic [BYTE_W-1:0]  frame_byte;
      logic               last_byte;
      logic [FLEN_W-1:0]  frame_length;
      logic [PTR_W-1:0]   read_pointer;
      logic [DROPS_W-1:0] drops_seen;
   } rrpd_result_type;

   // Parser to result register
   typedef struct packed {
      logic            load;
      rrpd_result_type result;
   } rrpd_push_type;

endpackage

>>> rtl/rrpd_channels.sv
// Valid/ready channel interfaces for ring bytes and deframer results.
// Depends on rrpd_pkg for field widths and the result kind type.
interface rrpd_req_if;
   logic                        valid;
   logic                        ready;
   logic [rrpd_pkg::BYTE_W-1:0] ring_byte;

   modport source (output valid, output ring_byte, input ready);
   modport sink   (input valid, input ring_byte, output ready);
endinterface

interface rrpd_rsp_if;
   logic                         valid;
   logic                         ready;
   rrpd_pkg::rrpd_kind_type      result_kind;
   logic [rrpd_pkg::BYTE_W-1:0]  frame_byte;
   logic                         last_byte;
   logic [rrpd_pkg::FLEN_W-1:0]  frame_length;
   logic [rrpd_pkg::PTR_W-1:0]   read_pointer;
   logic [rrpd_pkg::DROPS_W-1:0] drops_seen;

   modport source (output valid, output result_kind, output frame_byte, output last_byte,
                   output frame_length, output read_pointer, output drops_seen,
                   input ready);
   modport sink   (input valid, input result_kind, input frame_byte, input last_byte,
                   input frame_length, input read_pointer, input drops_seen,
                   output ready);
endinterface

>>> rtl/rrpd_in_stage.sv
// Input register for ring bytes.
// Depends on rrpd_pkg and the rrpd_req_if interface.
module rrpd_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   rrpd_req_if.sink                req_chan,
   input  logic                    take,
   output rrpd_pkg::rrpd_byte_type in_item
);

   logic                        valid_ff, valid_in;
   logic [rrpd_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        accept;

   // Take a new byte whenever the register is empty or being drained
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_chan.ring_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_item.valid     = valid_ff;
   assign in_item.ring_byte = byte_ff;

endmodule

>>> rtl/rrpd_parser.sv
// Header/payload/skip parser: holds the ring state and builds at most one result per byte.
// Depends on rrpd_pkg and the assertion macro header.
`include "rx_ring_packet_deframer_top_macros.svh"

module rrpd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rrpd_pkg::FLEN_W-1:0]   csr_wr_data,
   input  rrpd_pkg::rrpd_byte_type       in_item,
   input  logic                          out_room,
   output logic                          take,
   output rrpd_pkg::rrpd_push_type       push
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_SKIP    = 2'd2
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [rrpd_pkg::FLEN_W-1:0]    byte_count_ff, byte_count_in;
   logic                           status_good_ff, status_good_in;
   logic [rrpd_pkg::BYTE_W-1:0]    size_lo_ff, size_lo_in;
   logic [rrpd_pkg::SIZE_W-1:0]    size_ff, size_in;
   logic [rrpd_pkg::OFFSET_W-1:0]  read_offset_ff, read_offset_in;
   logic [rrpd_pkg::DROPS_W-1:0]   drop_count_ff, drop_count_in;
   logic [rrpd_pkg::FLEN_W-1:0]    max_frame_ff;

   logic [rrpd_pkg::FLEN_W-1:0]    payload_len;
   logic [rrpd_pkg::FLEN_W-1:0]    count_inc;
   logic [1:0]                     pad_len;
   logic [2:0]                     skip_len;
   logic [rrpd_pkg::HDR_W-1:0]     hdr_size;
   logic [rrpd_pkg::HDR_W-1:0]     size_limit;
   logic                           hdr_bad;
   logic [rrpd_pkg::OFFSET_W-1:0]  offset_sum;
   logic [rrpd_pkg::OFFSET_W-1:0]  next_offset;
   logic [rrpd_pkg::OFFSET_W-1:0]  host_ptr;
   logic                           emit;
   rrpd_pkg::rrpd_result_type      res;

   // Per-packet derived values
   assign payload_len = rrpd_pkg::FLEN_W'(size_ff - rrpd_pkg::SIZE_W'(rrpd_pkg::CRC_BYTES));
   assign count_inc   = byte_count_ff + 1'b1;
   assign pad_len     = 2'(2'd0 - size_ff[1:0]);
   assign skip_len    = 3'd4 + {1'b0, pad_len};
   assign hdr_size    = {in_item.ring_byte, size_lo_ff};
   assign size_limit  = rrpd_pkg::HDR_W'(max_frame_ff) + rrpd_pkg::CRC_BYTES;
   assign hdr_bad     = !status_good_ff || (hdr_size < rrpd_pkg::MIN_PACKET_SIZE) ||
                        (hdr_size > size_limit);

   // Advance the offset past CRC and padding, then bias it back for the host
   assign offset_sum  = read_offset_ff + rrpd_pkg::OFFSET_W'(size_ff) + rrpd_pkg::PAD_ROUND;
   assign next_offset = {offset_sum[rrpd_pkg::OFFSET_W-1:2], 2'b00};
   assign host_ptr    = (next_offset - rrpd_pkg::HOST_PTR_BIAS) & rrpd_pkg::RING_MASK;

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      status_good_in = status_good_ff;
      size_lo_in     = size_lo_ff;
      size_in        = size_ff;
      read_offset_in = read_offset_ff;
      drop_count_in  = drop_count_ff;
      emit           = 1'b0;
      res            = '0;
      res.drops_seen = drop_count_ff;

      unique case (phase_ff)
         PH_PAYLOAD: begin
            // Pass one frame byte, mark the last
            emit             = 1'b1;
            res.result_kind  = rrpd_pkg::KIND_FRAME;
            res.frame_byte   = in_item.ring_byte;
            res.last_byte    = (count_inc >= payload_len);
            res.frame_length = payload_len;
            if (count_inc >= payload_len) begin
               phase_in      = PH_SKIP;
               byte_count_in = '0;
            end else begin
               byte_count_in = count_inc;
            end
         end
         PH_SKIP: begin
            // Drop CRC and padding; report the host pointer on the last one
            if (count_inc >= rrpd_pkg::FLEN_W'(skip_len)) begin
               emit             = 1'b1;
               res.result_kind  = rrpd_pkg::KIND_DONE;
               res.frame_length = payload_len;
               res.read_pointer = host_ptr[rrpd_pkg::PTR_W-1:0];
               read_offset_in   = next_offset;
               phase_in         = PH_HEADER;
               byte_count_in    = '0;
            end else begin
               byte_count_in = count_inc;
            end
         end
         default: begin
            // Collect the four header bytes; drop the packet on a bad header
            phase_in = PH_HEADER;
            case (byte_count_ff[1:0])
               2'd0: status_good_in = in_item.ring_byte[0];
               2'd2: size_lo_in     = in_item.ring_byte;
               default: ;
            endcase
            if (byte_count_ff[1:0] != 2'd3) begin
               byte_count_in = rrpd_pkg::FLEN_W'(byte_count_ff[1:0]) + 1'b1;
            end else begin
               byte_count_in = '0;
               if (hdr_bad) begin
                  emit             = 1'b1;
                  drop_count_in    = drop_count_ff + 1'b1;
                  read_offset_in   = '0;
                  res.result_kind  = rrpd_pkg::KIND_DROP;
                  res.drops_seen   = drop_count_ff + 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
                  size_in  = hdr_size[rrpd_pkg::SIZE_W-1:0];
               end
            end
         end
      endcase
   end

   // Consume the byte unless its result has nowhere to go
   assign take        = in_item.valid && (!emit || out_room);
   assign push.load   = take && emit;
   assign push.result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         byte_count_ff  <= '0;
         status_good_ff <= 1'b0;
         size_lo_ff     <= '0;
         size_ff        <= '0;
         read_offset_ff <= '0;
         drop_count_ff  <= '0;
         max_frame_ff   <= rrpd_pkg::MAX_FRAME_RESET;
      end else begin
         if (csr_wr_en) begin
            max_frame_ff <= csr_wr_data;
         end
         if (take) begin
            phase_ff       <= phase_in;
            byte_count_ff  <= byte_count_in;
            status_good_ff <= status_good_in;
            size_lo_ff     <= size_lo_in;
            size_ff        <= size_in;
            read_offset_ff <= read_offset_in;
            drop_count_ff  <= drop_count_in;
         end
      end
   end

   `RRPD_ASSERT_NEXT(a_drop_counts_once, clock, reset,
      push.load && res.result_kind == rrpd_pkg::KIND_DROP,
      drop_count_ff == $past(drop_count_ff) + 32'd1)
   `RRPD_ASSERT(a_payload_count_bound, clock, reset,
      phase_ff == PH_PAYLOAD, byte_count_ff < payload_len)
   `RRPD_ASSERT(a_skip_count_bound, clock, reset,
      phase_ff == PH_SKIP, byte_count_ff < rrpd_pkg::FLEN_W'(skip_len))
   `RRPD_ASSERT(a_offset_aligned, clock, reset, 1'b1, read_offset_ff[1:0] == 2'd0)

endmodule

>>> rtl/rrpd_out_stage.sv
// Result register in front of the response channel.
// Depends on rrpd_pkg and the rrpd_rsp_if interface.
module rrpd_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  rrpd_pkg::rrpd_push_type push,
   output logic                    out_room,
   rrpd_rsp_if.source              rsp_chan
);

   logic                      valid_ff, valid_in;
   rrpd_pkg::rrpd_result_type res_ff, res_in;

   // Room when empty or when the held result leaves this cycle
   assign out_room = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (push.load) begin
         valid_in = 1'b1;
         res_in   = push.result;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.result_kind  = res_ff.result_kind;
   assign rsp_chan.frame_byte   = res_ff.frame_byte;
   assign rsp_chan.last_byte    = res_ff.last_byte;
   assign rsp_chan.frame_length = res_ff.frame_length;
   assign rsp_chan.read_pointer = res_ff.read_pointer;
   assign rsp_chan.drops_seen   = res_ff.drops_seen;

endmodule

>>> rtl/rx_ring_packet_deframer_top.sv
// Channel  | Dir | Payload                                                 | Handshake
// req_chan | in  | ring_byte                                               | valid/ready
// rsp_chan | out | result_kind frame_byte last_byte frame_length           | valid/ready
//          |     | read_pointer drops_seen                                 |
// csr      | in  | csr_wr_data (max frame length)                          | csr_wr_en
//
// One ring byte is taken per cycle unless an emitting byte waits on a full result register;
// its result, if any, passes the input register, then the result register, to rsp_chan.
// Header bytes of a good header and CRC/padding bytes before the last produce no result.
// Reset is synchronous; it clears the parser state and sets the max frame length to 1518.
// When rsp_chan stalls, the result register holds and backpressure reaches req_chan
// only once a byte that needs to emit is waiting in the input register.
module rx_ring_packet_deframer_top (
   input  logic                        clock,
   input  logic                        reset,
   rrpd_req_if.sink                    req_chan,
   rrpd_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [rrpd_pkg::FLEN_W-1:0] csr_wr_data
);

   rrpd_pkg::rrpd_byte_type in_item;
   rrpd_pkg::rrpd_push_type push;
   logic                    take;
   logic                    out_room;

   rrpd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .in_item  (in_item)
   );

   rrpd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_item     (in_item),
      .out_room    (out_room),
      .take        (take),
      .push        (push)
   );

   rrpd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .out_room (out_room),
      .rsp_chan (rsp_chan)
   );

endmodule
